@@ sv/lpmr_pkg.sv @@
// Package for the length-prefixed message ring: opcode and status codes,
// configuration command type and header byte helpers.
// No dependencies.
`default_nettype none

package lpmr_pkg;

   localparam int RING_BYTES_W = 13;
   localparam int MIN_SIZE     = 8;

   typedef enum logic [2:0] {
      OP_SEND_START = 3'd0,
      OP_SEND_BYTE  = 3'd1,
      OP_RECV_START = 3'd2,
      OP_RECV_BYTE  = 3'd3,
      OP_CLEAR      = 3'd4
   } opcode_type;

   localparam logic [1:0] ST_OK     = 2'd0;
   localparam logic [1:0] ST_NOROOM = 2'd1;
   localparam logic [1:0] ST_EMPTY  = 2'd2;
   localparam logic [1:0] ST_SEQ    = 2'd3;

   // register index taken from the word address
   localparam logic REG_RING_BYTES = 1'b0;

   typedef struct packed {
      logic                    clear;
      logic [RING_BYTES_W-1:0] ring_bytes;
   } cfg_cmd_type;

   // byte idx of the little-endian length header
   function automatic logic [7:0] hdr_byte(input logic [11:0] len, input logic [1:0] idx);
      logic [7:0] b;
      b = 8'h00;
      case (idx)
         2'd0:    b = len[7:0];
         2'd1:    b = {4'h0, len[11:8]};
         default: b = 8'h00;
      endcase
      return b;
   endfunction

   // fold header byte idx into the length being assembled
   function automatic logic [11:0] hdr_merge(input logic [11:0] len, input logic [1:0] idx,
                                             input logic [7:0] b);
      logic [11:0] r;
      r = len;
      case (idx)
         2'd0:    r[7:0] = b;
         2'd1:    r[11:8] = b[3:0];
         default: r = len;
      endcase
      return r;
   endfunction

endpackage

`default_nettype wire

@@ sv/lpmr_wrap_inc.sv @@
// Shared pointer advance unit: increment with wrap at the active ring size.
// No package dependency.
`default_nettype none

module lpmr_wrap_inc #(
   parameter int PW = 12,
   parameter int CW = 13
) (
   input  wire logic [PW-1:0] ptr,
   input  wire logic [CW-1:0] size,
   output logic      [PW-1:0] nxt
);

   logic [CW-1:0] sum;

   assign sum = CW'(ptr) + CW'(1);
   assign nxt = (sum >= size) ? '0 : sum[PW-1:0];

endmodule

`default_nettype wire

@@ sv/lpmr_ring_mem.sv @@
// Byte-wide ring store: one write port, one read port with registered data.
// No package dependency.
`default_nettype none

module lpmr_ring_mem #(
   parameter int DEPTH = 4096,
   parameter int AW    = 12
) (
   input  wire logic          clock,
   input  wire logic          we,
   input  wire logic [AW-1:0] waddr,
   input  wire logic [7:0]    wdata,
   input  wire logic          re,
   input  wire logic [AW-1:0] raddr,
   output logic      [7:0]    rdata
);

   logic [7:0] store_ff [DEPTH];
   logic [7:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         store_ff[waddr] <= wdata;
      end
      if (re) begin
         rdata_ff <= store_ff[raddr];
      end
   end

   assign rdata = rdata_ff;

endmodule

`default_nettype wire

@@ sv/lpmr_ctrl.sv @@
// Sequencer of the message ring: decodes items, moves header and payload
// bytes through the ring store, keeps pointers and free count. Uses lpmr_pkg
// and lpmr_wrap_inc.
`default_nettype none

module lpmr_ctrl #(
   parameter int RING_DEPTH   = 4096,
   parameter int HEADER_BYTES = 4,
   parameter int PW           = 12
) (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire lpmr_pkg::cfg_cmd_type cfg_i,
   input  wire logic                 req_tvalid,
   output logic                      req_tready,
   input  wire logic [2:0]           req_opcode,
   input  wire logic [11:0]          req_length,
   input  wire logic [7:0]           req_data,
   output logic                      rsp_tvalid,
   input  wire logic                 rsp_tready,
   output logic      [1:0]           rsp_status,
   output logic      [11:0]          rsp_length,
   output logic      [7:0]           rsp_byte,
   output logic                      rsp_last,
   output logic                      rsp_empty,
   output logic                      mem_we,
   output logic      [PW-1:0]        mem_waddr,
   output logic      [7:0]           mem_wdata,
   output logic                      mem_re,
   output logic      [PW-1:0]        mem_raddr,
   input  wire logic [7:0]           mem_rdata
);

   import lpmr_pkg::*;

   localparam int CW = ($clog2(RING_DEPTH + 1) > RING_BYTES_W) ?
                       $clog2(RING_DEPTH + 1) : RING_BYTES_W;
   localparam logic [1:0]  HB_LAST  = 2'(HEADER_BYTES - 1);
   localparam logic [11:0] LEN_MASK = (HEADER_BYTES * 8 >= 12) ? 12'hFFF :
                                      12'((1 << (HEADER_BYTES * 8)) - 1);
   localparam logic [CW-1:0] RESET_SIZE = (RING_DEPTH < 4096) ? CW'(RING_DEPTH) : CW'(4096);

   typedef enum logic [2:0] {
      S_IDLE,
      S_EXEC,
      S_WR_HDR,
      S_RD_ISSUE,
      S_RD_CAP,
      S_FIN
   } state_type;

   state_type     state_ff, state_in;
   logic [2:0]    op_ff, op_in;
   logic [11:0]   len_ff, len_in;
   logic [7:0]    data_ff, data_in;
   logic [1:0]    idx_ff, idx_in;
   logic [PW-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PW-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CW-1:0] free_ff, free_in;
   logic [CW-1:0] size_ff, size_in;
   logic [11:0]   send_left_ff, send_left_in;
   logic [11:0]   recv_left_ff, recv_left_in;
   logic [11:0]   total_ff, total_in;
   logic [1:0]    status_ff, status_in;
   logic [11:0]   olen_ff, olen_in;
   logic [7:0]    obyte_ff, obyte_in;
   logic          last_ff, last_in;
   logic          rsp_valid_ff, rsp_valid_in;
   logic [1:0]    rsp_status_ff, rsp_status_in;
   logic [11:0]   rsp_length_ff, rsp_length_in;
   logic [7:0]    rsp_byte_ff, rsp_byte_in;
   logic          rsp_last_ff, rsp_last_in;
   logic          rsp_empty_ff, rsp_empty_in;

   logic [PW-1:0] ptr_sel;
   logic [PW-1:0] ptr_nxt;
   logic [CW-1:0] size_new;
   logic [CW-1:0] rb_ext;
   logic [CW-1:0] need;
   logic [CW:0]   ret_sum;
   logic [11:0]   merged;
   logic [11:0]   hdr_len;
   logic          do_clear;

   lpmr_wrap_inc #(.PW(PW), .CW(CW)) u_wrap (
      .ptr  (ptr_sel),
      .size (size_ff),
      .nxt  (ptr_nxt)
   );

   // clamp the written ring size to the usable range
   assign rb_ext   = CW'(cfg_i.ring_bytes);
   assign size_new = (rb_ext < CW'(MIN_SIZE))   ? CW'(MIN_SIZE) :
                     (rb_ext > CW'(RING_DEPTH)) ? CW'(RING_DEPTH) : rb_ext;

   assign need    = CW'(len_ff) + CW'(HEADER_BYTES);
   assign ret_sum = {1'b0, free_ff} + (CW + 1)'(total_ff) + (CW + 1)'(HEADER_BYTES);
   assign merged  = hdr_merge(len_ff, idx_ff, mem_rdata);
   assign hdr_len = merged & LEN_MASK;

   assign req_tready = (state_ff == S_IDLE) && !cfg_i.clear;
   assign mem_waddr  = wr_ptr_ff;
   assign mem_raddr  = rd_ptr_ff;

   always_comb begin
      state_in      = state_ff;
      op_in         = op_ff;
      len_in        = len_ff;
      data_in       = data_ff;
      idx_in        = idx_ff;
      wr_ptr_in     = wr_ptr_ff;
      rd_ptr_in     = rd_ptr_ff;
      free_in       = free_ff;
      size_in       = size_ff;
      send_left_in  = send_left_ff;
      recv_left_in  = recv_left_ff;
      total_in      = total_ff;
      status_in     = status_ff;
      olen_in       = olen_ff;
      obyte_in      = obyte_ff;
      last_in       = last_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_tready;
      rsp_status_in = rsp_status_ff;
      rsp_length_in = rsp_length_ff;
      rsp_byte_in   = rsp_byte_ff;
      rsp_last_in   = rsp_last_ff;
      rsp_empty_in  = rsp_empty_ff;
      mem_we        = 1'b0;
      mem_wdata     = hdr_byte(len_ff, idx_ff);
      mem_re        = 1'b0;
      ptr_sel       = rd_ptr_ff;
      do_clear      = 1'b0;

      unique case (state_ff)
         S_IDLE: begin
            if (req_tvalid && req_tready) begin
               op_in    = req_opcode;
               len_in   = req_length & LEN_MASK;
               data_in  = req_data;
               state_in = S_EXEC;
            end
         end
         S_EXEC: begin
            status_in = ST_OK;
            olen_in   = '0;
            obyte_in  = '0;
            last_in   = 1'b0;
            idx_in    = '0;
            state_in  = S_FIN;
            unique case (op_ff)
               OP_SEND_START: begin
                  if (send_left_ff != '0) begin
                     status_in = ST_SEQ;
                  end else if (need > free_ff) begin
                     status_in = ST_NOROOM;
                  end else begin
                     free_in      = free_ff - need;
                     send_left_in = len_ff;
                     state_in     = S_WR_HDR;
                  end
               end
               OP_SEND_BYTE: begin
                  if (send_left_ff == '0) begin
                     status_in = ST_SEQ;
                  end else begin
                     mem_we       = 1'b1;
                     mem_wdata    = data_ff;
                     ptr_sel      = wr_ptr_ff;
                     wr_ptr_in    = ptr_nxt;
                     send_left_in = send_left_ff - 12'd1;
                     last_in      = (send_left_ff == 12'd1);
                  end
               end
               OP_RECV_START: begin
                  if (send_left_ff != '0 || recv_left_ff != '0) begin
                     status_in = ST_SEQ;
                  end else if (free_ff >= size_ff) begin
                     status_in = ST_EMPTY;
                  end else begin
                     len_in   = '0;
                     state_in = S_RD_ISSUE;
                  end
               end
               OP_RECV_BYTE: begin
                  if (recv_left_ff == '0) begin
                     status_in = ST_SEQ;
                  end else begin
                     state_in = S_RD_ISSUE;
                  end
               end
               OP_CLEAR: begin
                  do_clear = 1'b1;
               end
               default: begin
                  status_in = ST_SEQ;
               end
            endcase
         end
         S_WR_HDR: begin
            mem_we    = 1'b1;
            ptr_sel   = wr_ptr_ff;
            wr_ptr_in = ptr_nxt;
            if (idx_ff == HB_LAST) begin
               state_in = S_FIN;
            end else begin
               idx_in = idx_ff + 2'd1;
            end
         end
         S_RD_ISSUE: begin
            mem_re    = 1'b1;
            rd_ptr_in = ptr_nxt;
            state_in  = S_RD_CAP;
         end
         S_RD_CAP: begin
            if (op_ff == OP_RECV_BYTE) begin
               obyte_in     = mem_rdata;
               recv_left_in = recv_left_ff - 12'd1;
               if (recv_left_ff == 12'd1) begin
                  last_in  = 1'b1;
                  free_in  = (ret_sum > {1'b0, size_ff}) ? size_ff : ret_sum[CW-1:0];
                  total_in = '0;
               end
               state_in = S_FIN;
            end else begin
               len_in = merged;
               if (idx_ff == HB_LAST) begin
                  olen_in = hdr_len;
                  if (hdr_len == '0) begin
                     free_in = free_ff + CW'(HEADER_BYTES);
                  end else begin
                     recv_left_in = hdr_len;
                     total_in     = hdr_len;
                  end
                  state_in = S_FIN;
               end else begin
                  idx_in   = idx_ff + 2'd1;
                  state_in = S_RD_ISSUE;
               end
            end
         end
         S_FIN: begin
            if (!rsp_valid_ff || rsp_tready) begin
               rsp_valid_in  = 1'b1;
               rsp_status_in = status_ff;
               rsp_length_in = olen_ff;
               rsp_byte_in   = obyte_ff;
               rsp_last_in   = last_ff;
               rsp_empty_in  = (free_ff == size_ff);
               state_in      = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase

      // a register write resizes and empties the ring; a clear item empties it at its current size
      if (do_clear || cfg_i.clear) begin
         if (cfg_i.clear) begin
            size_in = size_new;
            free_in = size_new;
         end else begin
            free_in = size_ff;
         end
         wr_ptr_in    = '0;
         rd_ptr_in    = '0;
         send_left_in = '0;
         recv_left_in = '0;
         total_in     = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         wr_ptr_ff    <= '0;
         rd_ptr_ff    <= '0;
         free_ff      <= RESET_SIZE;
         size_ff      <= RESET_SIZE;
         send_left_ff <= '0;
         recv_left_ff <= '0;
         total_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         wr_ptr_ff    <= wr_ptr_in;
         rd_ptr_ff    <= rd_ptr_in;
         free_ff      <= free_in;
         size_ff      <= size_in;
         send_left_ff <= send_left_in;
         recv_left_ff <= recv_left_in;
         total_ff     <= total_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      op_ff         <= op_in;
      len_ff        <= len_in;
      data_ff       <= data_in;
      idx_ff        <= idx_in;
      status_ff     <= status_in;
      olen_ff       <= olen_in;
      obyte_ff      <= obyte_in;
      last_ff       <= last_in;
      rsp_status_ff <= rsp_status_in;
      rsp_length_ff <= rsp_length_in;
      rsp_byte_ff   <= rsp_byte_in;
      rsp_last_ff   <= rsp_last_in;
      rsp_empty_ff  <= rsp_empty_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_status = rsp_status_ff;
   assign rsp_length = rsp_length_ff;
   assign rsp_byte   = rsp_byte_ff;
   assign rsp_last   = rsp_last_ff;
   assign rsp_empty  = rsp_empty_ff;

   a_wr_ptr_in_ring: assert property (@(posedge clock) disable iff (reset)
      CW'(wr_ptr_ff) < size_ff)
      else $error("write pointer beyond active ring size");

   a_rd_ptr_in_ring: assert property (@(posedge clock) disable iff (reset)
      CW'(rd_ptr_ff) < size_ff)
      else $error("read pointer beyond active ring size");

   a_free_bound: assert property (@(posedge clock) disable iff (reset)
      free_ff <= size_ff)
      else $error("free count exceeds ring size");

   a_one_mem_access: assert property (@(posedge clock) disable iff (reset)
      !(mem_we && mem_re))
      else $error("ring store read and written in one cycle");

   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      (req_tvalid && req_tready) |=> !req_tready)
      else $error("second transfer taken while an item is in progress");

endmodule

`default_nettype wire

@@ sv/length_prefixed_message_ring.sv @@
// Top level of the length-prefixed message ring: register port, stream
// packing and instances of the sequencer and the ring store.
// Depends on lpmr_pkg, lpmr_ctrl and lpmr_ring_mem.
`default_nettype none

// A byte ring queuing variable-length messages, each stored as a
// HEADER_BYTES little-endian length followed by its payload. Every request
// transfer yields exactly one response transfer, in order. Send byte,
// clear, refused and out-of-sequence items are decoded and answered; an
// accepted send start first writes its header bytes, a receive byte first
// reads and captures its byte, and an accepted receive start first reads
// and captures each header byte. The ring store has one write port and one
// read port with registered data, and one pointer incrementer is shared by
// both pointers: headers move one byte per write cycle or per read/capture
// pair. A new request is taken in the cycle the response appears, even
// while that response waits for rsp_tready. Writing ring_bytes (byte
// address 0) clamps it to 8..RING_DEPTH, empties the ring and reads back as
// written; req_tready drops for the access cycle of that write. No clearing
// pass is needed after reset.
module length_prefixed_message_ring #(
   parameter int RING_DEPTH   = 4096,
   parameter int HEADER_BYTES = 4
) (
   input  wire logic        clock,
   input  wire logic        reset,
   // request stream
   input  wire logic        req_tvalid,
   output logic             req_tready,
   input  wire logic [23:0] req_tdata,   // [11:0] msg_length, [19:12] data_byte, [23:20] zero
   input  wire logic [2:0]  req_tuser,   // [2:0] opcode
   // response stream
   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   output logic      [23:0] rsp_tdata,   // [1:0] status, [13:2] out_length, [21:14] out_byte,
                                         // [22] is_empty, [23] zero
   output logic             rsp_tlast,
   // register port
   input  wire logic        csr_psel,
   input  wire logic        csr_penable,
   input  wire logic        csr_pwrite,
   input  wire logic [2:0]  csr_paddr,
   input  wire logic [31:0] csr_pwdata,
   output logic      [31:0] csr_prdata,
   output logic             csr_pready
);

   import lpmr_pkg::*;

   localparam int PW = $clog2(RING_DEPTH);

   logic [RING_BYTES_W-1:0] ring_bytes_ff, ring_bytes_in;
   logic                    wr_hit;
   cfg_cmd_type             cfg_cmd;

   logic          mem_we;
   logic [PW-1:0] mem_waddr;
   logic [7:0]    mem_wdata;
   logic          mem_re;
   logic [PW-1:0] mem_raddr;
   logic [7:0]    mem_rdata;

   logic [1:0]  rsp_status;
   logic [11:0] rsp_length;
   logic [7:0]  rsp_byte;
   logic        rsp_empty;

   // register port: no wait states, write lands on the access cycle
   assign csr_pready = 1'b1;
   assign wr_hit     = csr_psel && csr_penable && csr_pwrite && csr_pready &&
                       (csr_paddr[2] == REG_RING_BYTES);

   assign ring_bytes_in = wr_hit ? csr_pwdata[RING_BYTES_W-1:0] : ring_bytes_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         ring_bytes_ff <= RING_BYTES_W'(4096);
      end else begin
         ring_bytes_ff <= ring_bytes_in;
      end
   end

   // read back the raw value; addresses past the register read as zero
   assign csr_prdata = (csr_paddr[2] == REG_RING_BYTES) ? 32'(ring_bytes_ff) : 32'h0;

   // hand the new size over with the write so the sequencer resizes and clears
   assign cfg_cmd.clear      = wr_hit;
   assign cfg_cmd.ring_bytes = csr_pwdata[RING_BYTES_W-1:0];

   lpmr_ring_mem #(.DEPTH(RING_DEPTH), .AW(PW)) u_mem (
      .clock (clock),
      .we    (mem_we),
      .waddr (mem_waddr),
      .wdata (mem_wdata),
      .re    (mem_re),
      .raddr (mem_raddr),
      .rdata (mem_rdata)
   );

   lpmr_ctrl #(.RING_DEPTH(RING_DEPTH), .HEADER_BYTES(HEADER_BYTES), .PW(PW)) u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .cfg_i      (cfg_cmd),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_opcode (req_tuser),
      .req_length (req_tdata[11:0]),
      .req_data   (req_tdata[19:12]),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_status (rsp_status),
      .rsp_length (rsp_length),
      .rsp_byte   (rsp_byte),
      .rsp_last   (rsp_tlast),
      .rsp_empty  (rsp_empty),
      .mem_we     (mem_we),
      .mem_waddr  (mem_waddr),
      .mem_wdata  (mem_wdata),
      .mem_re     (mem_re),
      .mem_raddr  (mem_raddr),
      .mem_rdata  (mem_rdata)
   );

   // pack the response fields, lowest field first
   assign rsp_tdata = {1'b0, rsp_empty, rsp_byte, rsp_length, rsp_status};

endmodule

`default_nettype wire
